// ----- src/tfpr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tfpr_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int IDX_W        = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
    localparam int TICK_W       = 16;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_REARM = 2'd2;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(BUFFER_BYTES);

    typedef struct packed {
        logic take;      // process the word on the input channel
        logic rd_issue;  // read the store at the readout index
        logic load;      // move read data into the output register
        logic drop;      // output word has been taken
        logic advance;   // step the readout index
    } tfpr_cmd_t;

    typedef struct packed {
        logic close_fire;  // current input word closes a non-empty packet
        logic last;        // readout index is at the final byte
    } tfpr_stat_t;

endpackage
`default_nettype wire

// ----- src/tfpr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tfpr_ctrl
    import tfpr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic       m_tready,
    input  wire tfpr_stat_t stat,
    output tfpr_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid && stat.close_fire) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (m_tready) begin
                    cmd.drop = 1'b1;
                    if (stat.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/tfpr_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tfpr_dp
    import tfpr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tfpr_cmd_t         cmd,
    output tfpr_stat_t             stat,
    input  wire logic [1:0]        action,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              cfg_we,
    input  wire logic [TICK_W-1:0] cfg_wdata,
    output logic [TICK_W-1:0]      timeout_ticks,
    output logic                   out_valid,
    output logic [7:0]             frame_byte,
    output logic [IDX_W-1:0]       byte_index,
    output logic [CNT_W-1:0]       frame_length,
    output logic                   last_byte
);

    logic [7:0]        store_mem [BUFFER_BYTES];
    logic [7:0]        rdata_reg;

    logic [TICK_W-1:0] timeout_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              receiving_reg;
    logic              receiving_next;
    logic              enabled_reg;
    logic              enabled_next;
    logic [TICK_W-1:0] countdown_reg;
    logic [TICK_W-1:0] countdown_next;

    logic [IDX_W-1:0]  rd_idx_reg;
    logic [CNT_W-1:0]  len_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic              out_last_reg;

    logic              restart;
    logic [CNT_W-1:0]  wr_pos;
    logic              wr_en;
    logic              tick_close;

    // A byte starts a new packet when none is open or the store is full.
    assign restart    = !receiving_reg || (count_reg >= FULL_COUNT);
    assign wr_pos     = restart ? '0 : count_reg;
    assign wr_en      = cmd.take && (action == ACT_BYTE) && enabled_reg;
    assign tick_close = (action == ACT_TICK) && receiving_reg
                        && (countdown_reg == TICK_W'(1));

    assign stat.close_fire = tick_close && (count_reg != '0);
    assign stat.last       = ({1'b0, rd_idx_reg} + CNT_W'(1)) == len_reg;

    always_comb begin
        count_next     = count_reg;
        receiving_next = receiving_reg;
        enabled_next   = enabled_reg;
        countdown_next = countdown_reg;
        if (cmd.take) begin
            case (action)
                ACT_BYTE: begin
                    if (enabled_reg) begin
                        receiving_next = 1'b1;
                        count_next     = wr_pos + CNT_W'(1);
                        if (restart) begin
                            countdown_next = timeout_reg;
                        end
                    end
                end
                ACT_TICK: begin
                    if (receiving_reg) begin
                        countdown_next = countdown_reg - TICK_W'(1);
                        if (tick_close) begin
                            receiving_next = 1'b0;
                            enabled_next   = 1'b0;
                        end
                    end
                end
                ACT_REARM: begin
                    count_next   = '0;
                    enabled_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= TICK_W'(20);
            count_reg     <= '0;
            receiving_reg <= 1'b0;
            enabled_reg   <= 1'b1;
            countdown_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            receiving_reg <= receiving_next;
            enabled_reg   <= enabled_next;
            countdown_reg <= countdown_next;
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (cmd.drop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_pos[IDX_W-1:0]] <= rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rdata_reg <= store_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && stat.close_fire) begin
            rd_idx_reg <= '0;
            len_reg    <= count_reg;
        end else if (cmd.advance) begin
            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
        if (cmd.load) begin
            out_byte_reg <= rdata_reg;
            out_idx_reg  <= rd_idx_reg;
            out_last_reg <= stat.last;
        end
    end

    assign timeout_ticks = timeout_reg;
    assign out_valid     = out_valid_reg;
    assign frame_byte    = out_byte_reg;
    assign byte_index    = out_idx_reg;
    assign frame_length  = len_reg;
    assign last_byte     = out_last_reg;

endmodule
`default_nettype wire

// ----- src/timeout_framed_packet_receiver.sv -----
// Channel   Direction  Ports                       Contents
// s_        in         s_tvalid/s_tready/s_tdata   rx_byte; s_tuser carries action
// m_        out        m_tvalid/m_tready/m_tdata   frame_byte, byte_index, frame_length;
//                                                  m_tlast carries last_byte
// APB       in/out     psel/penable/pwrite/paddr   timeout_ticks at byte address 0
//
// An input word is taken while no packet is being read out.
// A closing tick for a non-empty packet starts the readout, which steps through
// store read, output load and output hold for each byte, waiting in output hold
// while m_tready is low; the packet store has a single registered read port.
// No input word is accepted until the last byte of a packet has been taken.
// aresetn is synchronous and active low; the packet store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module timeout_framed_packet_receiver
    import tfpr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] action

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] frame_byte, [13:8] byte_index,
                                        // [20:14] frame_length, [23:21] zero
    output logic             m_tlast,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    tfpr_cmd_t         cmd;
    tfpr_stat_t        stat;
    logic              cfg_we;
    logic [TICK_W-1:0] timeout_ticks;
    logic [7:0]        frame_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [CNT_W-1:0]  frame_length;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32 - TICK_W){1'b0}}, timeout_ticks};

    tfpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tfpr_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .action        (s_tuser),
        .rx_byte       (s_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (pwdata[TICK_W-1:0]),
        .timeout_ticks (timeout_ticks),
        .out_valid     (m_tvalid),
        .frame_byte    (frame_byte),
        .byte_index    (byte_index),
        .frame_length  (frame_length),
        .last_byte     (m_tlast)
    );

    assign m_tdata = {{(24 - 8 - IDX_W - CNT_W){1'b0}}, frame_length, byte_index, frame_byte};

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import tfpr_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam logic [2:0] TIMEOUT_ADDR = 3'd0;
    localparam int QUIET_LIMIT = 4000;
    localparam int CLOSE_GAP   = 16;
    localparam int TAIL_CYCLES = 100;
    localparam int PHASE_WORDS = 40;
    localparam int HOLD_CYCLES = 400;

    class frame_checker;
        typedef struct {
            logic [7:0]       value;
            logic [IDX_W-1:0] index;
            logic [CNT_W-1:0] length;
            logic             last;
        } frame_word_t;

        logic [7:0]        store [BUFFER_BYTES];
        logic [CNT_W-1:0]  fill;
        logic              in_packet;
        logic              rx_enabled;
        logic [TICK_W-1:0] countdown;
        logic [TICK_W-1:0] timeout_ticks;
        frame_word_t       frame_words_due [$];
        int words_in, frames, empty_frames, bytes_checked, errors;

        function new();
            fill          = '0;
            in_packet     = 1'b0;
            rx_enabled    = 1'b1;
            countdown     = '0;
            timeout_ticks = 16'd20;
            foreach (store[i]) store[i] = 8'h00;
            words_in      = 0;
            frames        = 0;
            empty_frames  = 0;
            bytes_checked = 0;
            errors        = 0;
        endfunction

        // Returns 1 for a byte while reception is on, a tick inside a packet, or a rearm.
        function bit note_word(logic [1:0] act, logic [7:0] b);
            frame_word_t w;
            bit live;
            live = 1'b0;
            words_in++;
            case (act)
                ACT_BYTE: begin
                    if (rx_enabled) begin
                        live = 1'b1;
                        // A full store restarts the packet with this byte first.
                        if (fill >= FULL_COUNT) begin
                            in_packet = 1'b0;
                            fill      = '0;
                        end
                        if (!in_packet) begin
                            in_packet = 1'b1;
                            fill      = '0;
                            countdown = timeout_ticks;
                        end
                        store[fill[IDX_W-1:0]] = b;
                        fill++;
                    end
                end
                ACT_TICK: begin
                    if (in_packet) begin
                        live = 1'b1;
                        countdown--;
                        if (countdown == '0) begin
                            in_packet  = 1'b0;
                            rx_enabled = 1'b0;
                            if (fill == '0) empty_frames++;
                            else frames++;
                            for (int k = 0; k < fill; k++) begin
                                w.value  = store[k];
                                w.index  = IDX_W'(k);
                                w.length = fill;
                                w.last   = (k + 1 == fill);
                                frame_words_due.push_back(w);
                            end
                        end
                    end
                end
                ACT_REARM: begin
                    live       = 1'b1;
                    fill       = '0;
                    rx_enabled = 1'b1;
                end
                default: ;
            endcase
            return live;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 30) $display("tb: mismatch: %s", msg);
        endtask

        task check_word(logic [23:0] data, logic last);
            frame_word_t want;
            if (frame_words_due.size() == 0) begin
                report_mismatch($sformatf("frame word %h last %b with none expected", data, last));
                return;
            end
            want = frame_words_due.pop_front();
            bytes_checked++;
            if (data[7:0] !== want.value || data[13:8] !== want.index ||
                data[20:14] !== want.length || last !== want.last || data[23:21] !== 3'b000) begin
                report_mismatch($sformatf(
                    "byte %0d of %0d: got %h idx %0d len %0d last %b pad %b, want %h last %b",
                    want.index, want.length, data[7:0], data[13:8], data[20:14], last,
                    data[23:21], want.value, want.last));
            end
        endtask

        function int pending();
            return frame_words_due.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic [1:0]  s_tuser  = 2'b00;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [7:0] frame_byte, [13:8] byte_index, [20:14] frame_length
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    frame_checker sb = new();
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_req       = 0;
    int hold_left      = 0;
    int quiet          = 0;
    int live_words     = 0;
    int settings_written = 0;

    timeout_framed_packet_receiver DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Receiver side: random stalls, plus a long hold-off when one is requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req > 0) begin
                hold_left = hold_req - 1;
                hold_req  = 0;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] act, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        if (sb.note_word(act, b)) live_words++;
    endtask

    // Waits until every expected word has come out and the block has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (CLOSE_GAP) @(posedge aclk);
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= {16'd0, ticks};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.timeout_ticks = ticks;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        psel    <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[15:0] !== ticks)
            sb.report_mismatch($sformatf("timeout read back %h, wrote %h", readback, ticks));
        settings_written++;
    endtask

    // One well-formed packet with random content, stray ticks, the odd rearm or unused code,
    // followed by some ignored noise and the rearm that reopens reception.
    task automatic run_packet();
        int want, sent, roll, byte_pct;
        roll = $urandom_range(99);
        if (roll < 70) want = $urandom_range(1, 6);
        else if (roll < 90) want = $urandom_range(7, 20);
        else if (roll < 98) want = $urandom_range(21, 64);
        else want = $urandom_range(65, 70);
        byte_pct = (want > 20) ? 97 : 75;
        sent = 0;
        while (sb.rx_enabled) begin
            roll = $urandom_range(99);
            if (sent < want && (sent == 0 || roll < byte_pct)) begin
                send_word(ACT_BYTE, 8'($urandom));
                sent++;
            end else if (sent >= want || roll < 96) begin
                send_word(ACT_TICK, 8'($urandom));
            end else if (roll < 98) begin
                send_word(ACT_REARM, 8'($urandom));
            end else begin
                send_word(ACT_UNUSED, 8'($urandom));
            end
        end
        repeat ($urandom_range(0, 2)) begin
            roll = $urandom_range(2);
            if (roll == 0) send_word(ACT_BYTE, 8'($urandom));
            else if (roll == 1) send_word(ACT_TICK, 8'($urandom));
            else send_word(ACT_UNUSED, 8'($urandom));
        end
        send_word(ACT_REARM, 8'($urandom));
    endtask

    function automatic logic [15:0] pick_timeout();
        return ($urandom_range(99) < 80) ? 16'($urandom_range(1, 8)) : 16'($urandom_range(9, 40));
    endfunction

    initial begin
        int goal;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset timeout: unused code and idle tick first, then a two-byte packet.
        send_word(ACT_UNUSED, 8'hFF);
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_BYTE, 8'hFF);
        while (sb.in_packet) send_word(ACT_TICK, 8'($urandom));
        send_word(ACT_BYTE, 8'h5A);    // reception is off after a close
        send_word(ACT_REARM, 8'h00);

        settle();
        set_timeout(16'd1);
        send_word(ACT_BYTE, 8'h81);
        send_word(ACT_TICK, 8'hFF);
        send_word(ACT_REARM, 8'hFF);

        // Rearm inside a packet keeps the countdown but restarts the byte count.
        settle();
        set_timeout(16'd3);
        send_word(ACT_BYTE, 8'h11);
        send_word(ACT_BYTE, 8'h22);
        send_word(ACT_REARM, 8'h33);
        send_word(ACT_BYTE, 8'h7E);
        while (sb.in_packet) send_word(ACT_TICK, 8'($urandom));
        send_word(ACT_REARM, 8'($urandom));

        // A rearm after the last byte leaves nothing to send when the packet closes.
        settle();
        set_timeout(16'd2);
        send_word(ACT_BYTE, 8'h44);
        send_word(ACT_REARM, 8'h00);
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_BYTE, 8'h99);
        send_word(ACT_REARM, 8'h00);

        // Zero timeout wraps the countdown; a store overflow is the way out.
        settle();
        set_timeout(16'd0);
        send_word(ACT_BYTE, 8'hA1);
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_TICK, 8'h00);
        settle();
        set_timeout(16'hFFFF);
        send_word(ACT_BYTE, 8'hA2);
        send_word(ACT_TICK, 8'h00);
        settle();
        set_timeout(16'd2);
        while (sb.fill < FULL_COUNT) send_word(ACT_BYTE, 8'($urandom));
        send_word(ACT_BYTE, 8'hE7);
        send_word(ACT_BYTE, 8'h18);
        while (sb.in_packet) send_word(ACT_TICK, 8'($urandom));
        send_word(ACT_REARM, 8'($urandom));

        // Full-size packet read out against a long receiver hold-off.
        settle();
        repeat (BUFFER_BYTES) send_word(ACT_BYTE, 8'($urandom));
        hold_req = HOLD_CYCLES;
        while (sb.in_packet) send_word(ACT_TICK, 8'($urandom));
        send_word(ACT_REARM, 8'($urandom));
        send_word(ACT_BYTE, 8'hC3);
        while (sb.in_packet) send_word(ACT_TICK, 8'($urandom));
        send_word(ACT_REARM, 8'($urandom));

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    src_idle_pct = 0;  sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 57; sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;  sink_stall_pct = 57;
                end
                default: begin
                    src_idle_pct = 37; sink_stall_pct = 37;
                end
            endcase
            settle();
            set_timeout(pick_timeout());
            goal = live_words + PHASE_WORDS;
            while (live_words < goal) begin
                if ($urandom_range(9) == 0) begin
                    settle();
                    set_timeout(pick_timeout());
                end
                run_packet();
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d frame words never arrived", sb.pending()));
        $display("tb: %0d input words (%0d effective), %0d frames and %0d empty closes, %0d bytes",
                 sb.words_in, live_words, sb.frames, sb.empty_frames, sb.bytes_checked);
        $display("tb: %0d timeout settings from 0 to 65535, %0d mismatches",
                 settings_written, sb.errors);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
src/tfpr_pkg.sv
src/tfpr_ctrl.sv
src/tfpr_dp.sv
src/timeout_framed_packet_receiver.sv
dv/tb.sv
